// ----- rtl/md5_byte_stream_hasher_macros.svh -----
// Assertion macros for the MD5 byte stream hasher.
// Used by the top level only; needs nothing else.
`ifndef MD5_BYTE_STREAM_HASHER_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MD5_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/md5_pkg.sv -----
// Shared types, constants and round functions of the MD5 byte stream hasher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_MAX = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [6:0] BLK_BYTES = 7'd64;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] SINE [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {group, round[1:0]}.
  localparam logic [4:0] ROT [0:15] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP0,
    ST_PREP1,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // How the next block's words are formed from the buffer.
  typedef enum logic [1:0] {
    BLK_KEEP,
    BLK_FULL,
    BLK_PAD,
    BLK_LEN
  } blk_t;

  typedef struct packed {
    logic wr_byte;
    logic wr_pad;
    blk_t blk;
    logic ld_work;
    logic pre_en;
    logic round_en;
    logic fold;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic pad_ovf;
    logic last_round;
    logic out_free;
  } sts_t;

  // Message word used by round j.
  function automatic logic [3:0] msg_index(input logic [5:0] j);
    logic [3:0] k;
    logic [3:0] idx;
    k = j[3:0];
    case (j[5:4])
      2'd0:    idx = k;
      2'd1:    idx = 4'(k * 4'd5 + 4'd1);
      2'd2:    idx = 4'(k * 4'd3 + 4'd5);
      default: idx = 4'(k * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/md5_stream_if.sv -----
// Channel interfaces of the MD5 byte stream hasher: request and digest.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface md5_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface md5_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_first_half;
  logic [63:0] digest_second_half;

  modport source (output valid, output digest_first_half, output digest_second_half,
                  input ready);
  modport sink   (input valid, input digest_first_half, input digest_second_half,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/md5_ctrl.sv -----
// Controller of the MD5 hasher: sequences absorb, padding and compression.
// Depends on md5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_req_type,
  output logic               in_ready,
  input  wire md5_pkg::sts_t sts,
  output md5_pkg::cmd_t      cmd
);

  md5_pkg::state_t state_r, state_nxt;
  logic fin_r, fin_nxt;
  logic ovf_r, ovf_nxt;
  logic in_fire;

  assign in_fire = in_valid && (state_r == md5_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5_pkg::ST_IDLE;
      fin_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      md5_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == md5_pkg::REQ_FINISH) begin
            state_nxt = md5_pkg::ST_PREP0;
            fin_nxt   = 1'b1;
            ovf_nxt   = sts.pad_ovf;
          end else if (sts.fill_last) begin
            state_nxt = md5_pkg::ST_PREP0;
          end
        end
      end
      md5_pkg::ST_PREP0: state_nxt = md5_pkg::ST_PREP1;
      md5_pkg::ST_PREP1: state_nxt = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: begin
        if (sts.last_round) begin
          state_nxt = md5_pkg::ST_FOLD;
        end
      end
      md5_pkg::ST_FOLD: begin
        // padding spilled over: run the length-only block next
        if (ovf_r) begin
          state_nxt = md5_pkg::ST_PREP0;
          ovf_nxt   = 1'b0;
        end else if (fin_r) begin
          state_nxt = md5_pkg::ST_EMIT;
        end else begin
          state_nxt = md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = md5_pkg::ST_IDLE;
          fin_nxt   = 1'b0;
        end
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == md5_pkg::ST_IDLE);
    cmd          = '0;
    cmd.blk      = md5_pkg::BLK_KEEP;
    case (state_r)
      md5_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == md5_pkg::REQ_FINISH) begin
            cmd.wr_pad = 1'b1;
            cmd.blk    = md5_pkg::BLK_PAD;
          end else begin
            cmd.wr_byte = 1'b1;
            cmd.blk     = sts.fill_last ? md5_pkg::BLK_FULL : md5_pkg::BLK_KEEP;
          end
        end
      end
      md5_pkg::ST_PREP0: cmd.ld_work = 1'b1;
      md5_pkg::ST_PREP1: cmd.pre_en = 1'b1;
      md5_pkg::ST_ROUND: begin
        cmd.pre_en   = 1'b1;
        cmd.round_en = 1'b1;
      end
      md5_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (ovf_r) begin
          cmd.blk = md5_pkg::BLK_LEN;
        end
      end
      md5_pkg::ST_EMIT: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/md5_dp.sv -----
// Datapath of the MD5 hasher: block buffer, round unit, chaining words,
// length counter and digest output register. Depends on md5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_data_byte,
  input  wire md5_pkg::cmd_t cmd,
  output md5_pkg::sts_t      sts,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [63:0]        out_first,
  output logic [63:0]        out_second
);

  // Block buffer: 16 words, byte-lane writes, registered read.
  logic [31:0] mem_r [16];
  logic [31:0] rd_q_r;
  logic [3:0]  rd_widx_r;
  logic [3:0]  rd_addr;
  logic [3:0]  wr_word;
  logic [1:0]  wr_lane;
  logic [7:0]  wr_data;
  logic        wr_en;

  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic [6:0]  vlen_r, vlen_nxt;
  logic        len_en_r, len_en_nxt;
  logic [5:0]  rs_r, rs_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] pre_r;
  logic [63:0] dig_lo_r, dig_hi_r;

  logic [63:0] bit_len;
  logic [31:0] w_word;
  logic [31:0] w_masked;
  logic [31:0] pre_base;
  logic [5:0]  k_idx;
  logic [31:0] nb;

  assign wr_en   = cmd.wr_byte || cmd.wr_pad;
  assign wr_word = fill_r[5:2];
  assign wr_lane = fill_r[1:0];
  assign wr_data = cmd.wr_pad ? md5_pkg::PAD_BYTE : in_data_byte;
  assign rd_addr = cmd.ld_work ? md5_pkg::msg_index(6'd0) : md5_pkg::msg_index(rs_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_word][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
    rd_q_r    <= mem_r[rd_addr];
    rd_widx_r <= rd_addr;
  end

  // Bytes past the valid length read as zero; in a length block the last two words carry the bit length.
  assign bit_len = {msg_r, 3'b000};
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      w_masked[l*8 +: 8] = ({1'b0, rd_widx_r, 2'(l)} < vlen_r) ? rd_q_r[l*8 +: 8] : 8'h00;
    end
    if (len_en_r && rd_widx_r == 4'd14) begin
      w_word = bit_len[31:0];
    end else if (len_en_r && rd_widx_r == 4'd15) begin
      w_word = bit_len[63:32];
    end else begin
      w_word = w_masked;
    end
  end

  // Lookahead: fold the next round's a, sine constant and message word into pre_r.
  assign k_idx    = 6'(rs_r - 6'd1);
  assign pre_base = cmd.round_en ? d_r : a_r;
  assign nb = b_r + md5_pkg::rotl32(md5_pkg::round_f(rnd_r[5:4], b_r, c_r, d_r) + pre_r,
                                    md5_pkg::ROT[{rnd_r[5:4], rnd_r[1:0]}]);

  always_ff @(posedge clk) begin
    if (cmd.pre_en) begin
      pre_r <= pre_base + md5_pkg::SINE[k_idx] + w_word;
    end
    if (cmd.ld_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
    end else if (cmd.round_en) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= nb;
    end
    if (cmd.emit) begin
      dig_lo_r <= {h_r[1], h_r[0]};
      dig_hi_r <= {h_r[3], h_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= md5_pkg::IV_A;
      h_r[1] <= md5_pkg::IV_B;
      h_r[2] <= md5_pkg::IV_C;
      h_r[3] <= md5_pkg::IV_D;
    end else if (cmd.fold) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
    end else if (cmd.emit) begin
      h_r[0] <= md5_pkg::IV_A;
      h_r[1] <= md5_pkg::IV_B;
      h_r[2] <= md5_pkg::IV_C;
      h_r[3] <= md5_pkg::IV_D;
    end
  end

  always_comb begin
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    vlen_nxt      = vlen_r;
    len_en_nxt    = len_en_r;
    rs_nxt        = rs_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r;
    if (cmd.wr_byte) begin
      fill_nxt = fill_r + 6'd1;
      msg_nxt  = msg_r + 61'd1;
    end
    case (cmd.blk)
      md5_pkg::BLK_FULL: begin
        vlen_nxt   = md5_pkg::BLK_BYTES;
        len_en_nxt = 1'b0;
      end
      md5_pkg::BLK_PAD: begin
        vlen_nxt   = {1'b0, fill_r} + 7'd1;
        len_en_nxt = (fill_r < md5_pkg::LEN_POS);
      end
      md5_pkg::BLK_LEN: begin
        vlen_nxt   = 7'd0;
        len_en_nxt = 1'b1;
      end
      default: begin
        vlen_nxt   = vlen_r;
        len_en_nxt = len_en_r;
      end
    endcase
    if (cmd.ld_work) begin
      rs_nxt  = 6'd1;
      rnd_nxt = 6'd0;
    end else begin
      if (cmd.pre_en) begin
        rs_nxt = rs_r + 6'd1;
      end
      if (cmd.round_en) begin
        rnd_nxt = rnd_r + 6'd1;
      end
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      fill_nxt      = 6'd0;
      msg_nxt       = 61'd0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 6'd0;
      msg_r       <= 61'd0;
      vlen_r      <= 7'd0;
      len_en_r    <= 1'b0;
      rs_r        <= 6'd0;
      rnd_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      vlen_r      <= vlen_nxt;
      len_en_r    <= len_en_nxt;
      rs_r        <= rs_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.fill_last  = (fill_r == md5_pkg::FILL_MAX);
  assign sts.pad_ovf    = (fill_r >= md5_pkg::LEN_POS);
  assign sts.last_round = (rnd_r == md5_pkg::LAST_RND);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_first  = dig_lo_r;
  assign out_second = dig_hi_r;

endmodule

`default_nettype wire

// ----- rtl/md5_byte_stream_hasher.sv -----
// Top level of the MD5 byte stream hasher: controller plus datapath.
// Depends on md5_pkg, md5_stream_if, md5_ctrl, md5_dp and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_byte_stream_hasher_macros.svh"

// MD5 over a byte stream. Each absorb transfer stores one byte; the transfer that
// completes a 64-byte block is followed by a busy period: ST_PREP0 and ST_PREP1
// prime the message-word read, 64 rounds run on the single round unit, and a fold
// adds the result into the chaining words. A finish transfer pads in its own cycle,
// then runs one block, or two when 56 or more bytes were buffered, and then loads
// the digest register and returns the chaining words to the initial value. The
// digest waits in that register until taken while new bytes are accepted; a later
// finish holds in the emit state only if the previous digest is still waiting.
module md5_byte_stream_hasher (
  input  wire logic  clk,
  input  wire logic  rst_n,
  md5_req_if.sink    in_ch,
  md5_dig_if.source  out_ch
);

  md5_pkg::cmd_t cmd;
  md5_pkg::sts_t sts;

  md5_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  md5_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_ch.data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_first    (out_ch.digest_first_half),
    .out_second   (out_ch.digest_second_half)
  );

  `MD5_ASSERT_NEXT(a_last_round_folds, clk, rst_n, cmd.round_en && sts.last_round, cmd.fold,
                   "last round not followed by fold")
  `MD5_ASSERT_SAME(a_emit_slot_free, clk, rst_n, cmd.emit, !out_ch.valid || out_ch.ready,
                   "digest overwritten while still pending")
  `MD5_ASSERT_NEXT(a_finish_busy, clk, rst_n,
                   in_ch.valid && in_ch.ready && in_ch.req_type == md5_pkg::REQ_FINISH,
                   !in_ch.ready && cmd.ld_work, "finish transfer did not start a block")

endmodule

`default_nettype wire
